### src/qau_pkg.sv
// ---------------------------------------------------------------------------
// qau_pkg: shared types for the quaternion arithmetic unit
// Operation codes, operand classification and front-to-back control.
// ---------------------------------------------------------------------------
package qau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_CONJ  = 3'd3,
    OP_SCALE = 3'd4,
    OP_DOT   = 3'd5,
    OP_ROT   = 3'd6,
    OP_MAT   = 3'd7
  } op_t;

  // second multiplier operand
  typedef enum logic [1:0] {
    QSEL_B = 2'd0,
    QSEL_A = 2'd1,
    QSEL_F = 2'd2
  } qsel_t;

  typedef struct packed {
    op_t   op;
    qsel_t qsel;
  } cls_t;

  typedef struct packed {
    logic valid;
    cls_t cls;
  } q_ctl_t;

endpackage

### src/quaternion_arithmetic_unit_core.sv
// ---------------------------------------------------------------------------
// quaternion_arithmetic_unit_core: fixed-point quaternion alu
// Add, subtract, hamilton product, conjugate, scale, dot, rotate, matrix.
// ---------------------------------------------------------------------------
// Each item passes the queue, then the stage 1, 2, 3 and output registers.
// Throughput: one item per cycle while not stalled; the matrix opcode holds
// the output for its four rows (one row per cycle when out_stall is low).
// Reset: synchronous, clears the queue and all pipeline valid bits.
module quaternion_arithmetic_unit_core #(
  parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    opcode,
  input  logic signed [DATA_WIDTH-1:0]  a_w,
  input  logic signed [DATA_WIDTH-1:0]  a_x,
  input  logic signed [DATA_WIDTH-1:0]  a_y,
  input  logic signed [DATA_WIDTH-1:0]  a_z,
  input  logic signed [DATA_WIDTH-1:0]  b_w,
  input  logic signed [DATA_WIDTH-1:0]  b_x,
  input  logic signed [DATA_WIDTH-1:0]  b_y,
  input  logic signed [DATA_WIDTH-1:0]  b_z,
  input  logic signed [DATA_WIDTH-1:0]  factor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  res_0,
  output logic signed [DATA_WIDTH-1:0]  res_1,
  output logic signed [DATA_WIDTH-1:0]  res_2,
  output logic signed [DATA_WIDTH-1:0]  res_3,
  output logic                          last,
  output logic                          overflow
);
  import qau_pkg::*;

  logic [9*DATA_WIDTH-1:0] in_data;
  logic [9*DATA_WIDTH-1:0] q_data;
  q_ctl_t                  q_ctl;
  logic                    q_pop;

  // item payload packed low field first
  assign in_data = {factor, b_z, b_y, b_x, b_w, a_z, a_y, a_x, a_w};

  qau_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .in_data  (in_data),
    .q_ctl    (q_ctl),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  qau_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_ctl     (q_ctl),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_0     (res_0),
    .res_1     (res_1),
    .res_2     (res_2),
    .res_3     (res_3),
    .last      (last),
    .overflow  (overflow)
  );

endmodule

### src/qau_front.sv
// ---------------------------------------------------------------------------
// qau_front: item intake and two-entry queue
// Classifies each item by opcode and buffers it for the compute pipeline.
// ---------------------------------------------------------------------------
module qau_front #(
  parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                opcode,
  input  logic [9*DATA_WIDTH-1:0]   in_data,
  output qau_pkg::q_ctl_t           q_ctl,
  output logic [9*DATA_WIDTH-1:0]   q_data,
  input  logic                      q_pop
);
  import qau_pkg::*;

  cls_t                    mem_cls  [2];
  logic [9*DATA_WIDTH-1:0] mem_data [2];
  logic                    wptr;
  logic                    rptr;
  logic [1:0]              cnt;
  logic                    push;
  cls_t                    cls_in;

  // opcode classification
  always_comb begin
    cls_in.op = op_t'(opcode);
    case (op_t'(opcode))
      OP_MAT:   cls_in.qsel = QSEL_A;
      OP_SCALE: cls_in.qsel = QSEL_F;
      default:  cls_in.qsel = QSEL_B;
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_cls[wptr]  <= cls_in;
      mem_data[wptr] <= in_data;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  assign q_ctl.valid = (cnt != 2'd0);
  assign q_ctl.cls   = mem_cls[rptr];
  assign q_data      = mem_data[rptr];

endmodule

### src/qau_back.sv
// ---------------------------------------------------------------------------
// qau_back: quaternion compute pipeline
// Multiply, sum/saturate, second multiply, second sum and the output register.
// ---------------------------------------------------------------------------
module qau_back #(
  parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qau_pkg::q_ctl_t               q_ctl,
  input  logic [9*DATA_WIDTH-1:0]       q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  res_0,
  output logic signed [DATA_WIDTH-1:0]  res_1,
  output logic signed [DATA_WIDTH-1:0]  res_2,
  output logic signed [DATA_WIDTH-1:0]  res_3,
  output logic                          last,
  output logic                          overflow
);
  import qau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int MW = W + 1;
  localparam int PW = 2 * MW;
  localparam int SW = PW - F + 3;

  typedef logic signed [W-1:0]  dat_t;
  typedef logic signed [MW-1:0] mul_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef sum_t sq_t [16];
  typedef sum_t sv4_t [4];
  typedef struct packed {
    logic         o;
    logic [W-1:0] v;
  } sat_t;

  function automatic sum_t shf(input prod_t p);
    return sum_t'($signed(p[PW-1:F]));
  endfunction

  function automatic sat_t sat(input sum_t v);
    sat_t r;
    r.o = (v[SW-1:W-1] != {(SW-W+1){v[SW-1]}});
    if (r.o) r.v = v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else     r.v = v[W-1:0];
    return r;
  endfunction

  // hamilton product, s[i*4+j] = p_i * q_j
  function automatic sv4_t hprod(input sq_t s);
    sv4_t r;
    r[0] = s[0] - s[5] - s[10] - s[15];
    r[1] = s[1] + s[4] + s[11] - s[14];
    r[2] = s[2] + s[8] + s[13] - s[7];
    r[3] = s[3] + s[12] + s[6] - s[9];
    return r;
  endfunction

  logic  adv;
  logic  done;
  logic  [1:0] row;

  // stage 1 registers
  logic  v1;
  op_t   op1;
  dat_t  a1 [4];
  dat_t  b1 [4];
  prod_t p1 [4][4];
  // stage 2 registers
  logic  v2;
  op_t   op2;
  dat_t  rows2 [3][4];
  logic  [2:0] ovf2;
  mul_t  c2 [4];
  // stage 3 registers
  logic  v3;
  op_t   op3;
  dat_t  rows3 [3][4];
  logic  [2:0] ovf3;
  prod_t p3 [4][4];
  // output registers
  logic  v4;
  op_t   op4;
  dat_t  rows4 [3][4];
  logic  [2:0] ovf4;

  dat_t  in_a [4];
  dat_t  in_b [4];
  dat_t  in_f;
  dat_t  qv   [4];
  prod_t p1_n [4][4];
  sq_t   s1;
  sv4_t  h1;
  sum_t  m1 [3][3];
  dat_t  rows2_n [3][4];
  logic  [2:0] ovf2_n;
  mul_t  c2_n [4];
  sat_t  st;
  sq_t   s3;
  sv4_t  h3;
  sat_t  st3;
  dat_t  rows4_n [3][4];
  logic  [2:0] ovf4_n;
  sum_t  one_s;
  sat_t  one_sat;
  logic  [1:0] rsel;

  // pipeline advance
  assign done  = v4 && !out_stall && last;
  assign adv   = !v4 || done;
  assign q_pop = adv && q_ctl.valid;

  // first multiply: a times b, a, or the factor
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_a[k] = q_data[k*W +: W];
      in_b[k] = q_data[(k+4)*W +: W];
    end
    in_f = q_data[8*W +: W];
    for (int j = 0; j < 4; j++) begin
      case (q_ctl.cls.qsel)
        QSEL_A:  qv[j] = in_a[j];
        QSEL_F:  qv[j] = in_f;
        default: qv[j] = in_b[j];
      endcase
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        p1_n[i][j] = prod_t'(in_a[i]) * prod_t'(qv[j]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= q_ctl.cls.op;
      a1  <= in_a;
      b1  <= in_b;
      p1  <= p1_n;
    end
  end

  // sums and saturation per opcode
  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        s1[i*4+j] = shf(p1[i][j]);
    h1    = hprod(s1);
    one_s = sum_t'(1) << F;
    // matrix rows 0..2, columns 0..2
    m1[0][0] = one_s - ((s1[10] + s1[15]) <<< 1);
    m1[0][1] = (s1[6] - s1[12]) <<< 1;
    m1[0][2] = (s1[7] + s1[8]) <<< 1;
    m1[1][0] = (s1[6] + s1[12]) <<< 1;
    m1[1][1] = one_s - ((s1[5] + s1[15]) <<< 1);
    m1[1][2] = (s1[11] - s1[4]) <<< 1;
    m1[2][0] = (s1[7] - s1[8]) <<< 1;
    m1[2][1] = (s1[11] + s1[4]) <<< 1;
    m1[2][2] = one_s - ((s1[5] + s1[10]) <<< 1);
    st = '0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 4; k++)
        rows2_n[r][k] = '0;
    ovf2_n  = '0;
    c2_n[0] = mul_t'(a1[0]);
    for (int k = 1; k < 4; k++) c2_n[k] = -mul_t'(a1[k]);
    case (op1)
      OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_SCALE, OP_ROT: begin
        for (int k = 0; k < 4; k++) begin
          case (op1)
            OP_ADD:   st = sat(sum_t'(a1[k]) + sum_t'(b1[k]));
            OP_SUB:   st = sat(sum_t'(a1[k]) - sum_t'(b1[k]));
            OP_CONJ:  st = sat(k == 0 ? sum_t'(a1[k]) : -sum_t'(a1[k]));
            OP_SCALE: st = sat(s1[k*4]);
            default:  st = sat(h1[k]);
          endcase
          rows2_n[0][k] = st.v;
          ovf2_n[0]     = ovf2_n[0] | st.o;
        end
      end
      OP_DOT: begin
        st            = sat(s1[0] + s1[5] + s1[10] + s1[15]);
        rows2_n[0][0] = st.v;
        ovf2_n[0]     = st.o;
      end
      OP_MAT: begin
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++) begin
            st            = sat(m1[r][k]);
            rows2_n[r][k] = st.v;
            ovf2_n[r]     = ovf2_n[r] | st.o;
          end
      end
      default: ovf2_n = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2   <= op1;
      rows2 <= rows2_n;
      ovf2  <= ovf2_n;
      c2    <= c2_n;
    end
  end

  // second multiply: saturated a*b times conj(a)
  always_ff @(posedge clk) begin
    if (adv) begin
      op3   <= op2;
      rows3 <= rows2;
      ovf3  <= ovf2;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          p3[i][j] <= prod_t'(rows2[0][i]) * prod_t'(c2[j]);
    end
  end

  // second sum for rotate
  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        s3[i*4+j] = shf(p3[i][j]);
    h3      = hprod(s3);
    rows4_n = rows3;
    ovf4_n  = ovf3;
    st3     = '0;
    if (op3 == OP_ROT) begin
      for (int k = 0; k < 4; k++) begin
        st3           = sat(h3[k]);
        rows4_n[0][k] = st3.v;
        ovf4_n[0]     = ovf4_n[0] | st3.o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op4   <= op3;
      rows4 <= rows4_n;
      ovf4  <= ovf4_n;
    end
  end

  // valid bits and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      row <= 2'd0;
    end else begin
      if (adv) begin
        v1  <= q_ctl.valid;
        v2  <= v1;
        v3  <= v2;
        v4  <= v3;
        row <= 2'd0;
      end else if (v4 && !out_stall) begin
        row <= row + 2'd1;
      end
    end
  end

  // output selection, matrix row 3 is constant
  always_comb begin
    one_sat   = sat(sum_t'(1) << F);
    rsel      = (row == 2'd3) ? 2'd0 : row;
    out_valid = v4;
    last      = (op4 != OP_MAT) || (row == 2'd3);
    if (op4 == OP_MAT && row == 2'd3) begin
      res_0    = '0;
      res_1    = '0;
      res_2    = '0;
      res_3    = one_sat.v;
      overflow = one_sat.o;
    end else begin
      res_0    = rows4[rsel][0];
      res_1    = rows4[rsel][1];
      res_2    = rows4[rsel][2];
      res_3    = rows4[rsel][3];
      overflow = ovf4[rsel];
    end
  end

  a_row_only_matrix: assert property (@(posedge clk) disable iff (rst)
    (row != 2'd0) |-> (v4 && op4 == OP_MAT))
    else $error("row counter moved on a single-result item");

  a_matrix_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (out_valid && row == $past(row) + 2'd1))
    else $error("matrix rows not delivered in sequence");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_ctl.valid)
    else $error("pop from empty queue");

endmodule
